// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, skipped while in reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition holds at the same edge where a trigger holds.
`define ASSERT_IMPLY(label, trig, cond, msg) \
	`ASSERT_CLK(label, (trig) |-> (cond), msg)

// Check that a condition holds at the edge after the one where a trigger holds.
`define ASSERT_NEXT(label, trig, cond, msg) \
	`ASSERT_CLK(label, (trig) |=> (cond), msg)

`endif

// File: hdl/tpfc_pkg.sv
package tpfc_pkg;

	localparam int SYM_W     = 8;
	localparam int VERDICT_W = 2;
	localparam int NUM_W     = 16;

	localparam logic [NUM_W-1:0] NUM_MAX = '1;

	localparam logic [VERDICT_W-1:0] V_GOOD    = 2'd0;
	localparam logic [VERDICT_W-1:0] V_BAD     = 2'd1;
	localparam logic [VERDICT_W-1:0] V_FULL    = 2'd2;
	localparam logic [VERDICT_W-1:0] V_IGNORED = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD_CHILD,
		S_RD_NODE,
		S_DONE
	} state_t;

endpackage

// File: hdl/tpfc_child_mem.sv
module tpfc_child_mem
	import tpfc_pkg::*;
#(
	parameter int NODE_W = 10
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [NODE_W+SYM_W-1:0] waddr,
	input  logic [NODE_W-1:0]       wdata,
	input  logic                    re,
	input  logic [NODE_W+SYM_W-1:0] raddr,
	output logic [NODE_W-1:0]       rdata
);

	localparam int DEPTH = (1 << (NODE_W + SYM_W));

	logic [NODE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/tpfc_node_mem.sv
module tpfc_node_mem
	import tpfc_pkg::*;
#(
	parameter int NODES  = 1024,
	parameter int NODE_W = 10
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [NODE_W-1:0]         waddr,
	input  logic [NODE_W+SYM_W:0]     wdata,
	input  logic                      re,
	input  logic [NODE_W-1:0]         raddr,
	output logic [NODE_W+SYM_W:0]     rdata
);

	// Each entry: terminal flag above the parent slot that owns the node.
	logic [NODE_W+SYM_W:0] mem [NODES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/trie_prefix_free_checker_unit.sv
// Prefix-free checker: strings arrive one byte per beat with last on the final byte, and
// each string gets one verdict beat on its final byte. A byte that walks the trie passes
// through the states in order: S_IDLE accepts it and issues the child table read,
// S_RD_CHILD reads the child's node entry (parent slot and terminal flag) that proves the
// child link was written since reset, S_RD_NODE updates the walk and allocates, and S_DONE
// issues the verdict on a final byte before the next byte can be accepted. Bytes that
// follow a dry node pool in the same string, and all bytes once a bad or full verdict has
// been given, skip the walk and go from S_IDLE straight to S_DONE. A final byte waits
// further while an earlier verdict beat is still stalled. No clearing pass is needed after
// reset: a child link counts only if it names an allocated node whose recorded parent slot
// is the slot being read, so the block accepts bytes right after reset.
module trie_prefix_free_checker_unit
	import tpfc_pkg::*;
#(
	parameter int NODES = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [SYM_W-1:0]     symbol,
	input  logic                 last,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [VERDICT_W-1:0] verdict,
	output logic [NUM_W-1:0]     string_number
);

	`include "assert_macros.svh"

	localparam int NODE_W = $clog2(NODES);
	localparam int CNT_W  = NODE_W + 1;
	localparam int SLOT_W = NODE_W + SYM_W;

	localparam logic [CNT_W-1:0] NODES_C = CNT_W'(NODES);

	state_t state_q, state_d;

	logic [NODE_W-1:0]    cur_q;
	logic [CNT_W-1:0]     next_free_q;
	logic                 made_q, met_q, bad_q, exh_q;
	logic [NUM_W-1:0]     seen_q;
	logic                 out_valid_q;

	logic [SLOT_W-1:0]    slot_q, cur_slot_q;
	logic                 last_q;
	logic [VERDICT_W-1:0] verdict_q;
	logic [NUM_W-1:0]     number_q;

	logic                 child_we, child_re;
	logic [SLOT_W-1:0]    child_waddr, child_raddr;
	logic [NODE_W-1:0]    child_wdata, child_rd;
	logic                 node_we, node_re;
	logic [NODE_W-1:0]    node_waddr;
	logic [SLOT_W:0]      node_wdata, node_rd;

	logic                 child_ok, has_room, load_out, skip_walk;
	logic [VERDICT_W-1:0] verdict_d;

	tpfc_child_mem #(.NODE_W(NODE_W)) u_child (
		.clk  (clk),
		.we   (child_we),
		.waddr(child_waddr),
		.wdata(child_wdata),
		.re   (child_re),
		.raddr(child_raddr),
		.rdata(child_rd)
	);

	tpfc_node_mem #(.NODES(NODES), .NODE_W(NODE_W)) u_node (
		.clk  (clk),
		.we   (node_we),
		.waddr(node_waddr),
		.wdata(node_wdata),
		.re   (node_re),
		.raddr(child_rd),
		.rdata(node_rd)
	);

	// A link is real only if the child is allocated and was allocated under this slot.
	// An unknown or unproven link counts as absent.
	always_comb begin
		child_ok = 1'b0;
		if ((child_rd != '0) && ({1'b0, child_rd} < next_free_q)
				&& (node_rd[SLOT_W-1:0] == slot_q)) begin
			child_ok = 1'b1;
		end
	end

	assign has_room  = next_free_q < NODES_C;
	assign skip_walk = bad_q || exh_q;

	always_comb begin
		if (bad_q) begin
			verdict_d = V_IGNORED;
		end else if (met_q) begin
			verdict_d = V_BAD;
		end else if (exh_q) begin
			verdict_d = V_FULL;
		end else if (!made_q) begin
			verdict_d = V_BAD;
		end else begin
			verdict_d = V_GOOD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		child_re    = 1'b0;
		child_raddr = {cur_q, symbol};
		child_we    = 1'b0;
		child_waddr = slot_q;
		child_wdata = next_free_q[NODE_W-1:0];
		node_re     = 1'b0;
		node_we     = 1'b0;
		node_waddr  = next_free_q[NODE_W-1:0];
		node_wdata  = {1'b0, slot_q};
		load_out    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					child_re = !skip_walk;
					state_d  = skip_walk ? S_DONE : S_RD_CHILD;
				end
			end
			S_RD_CHILD: begin
				node_re = 1'b1;
				state_d = S_RD_NODE;
			end
			S_RD_NODE: begin
				// Allocate: link the slot and record the new node's owner, terminal clear.
				if (!child_ok && has_room) begin
					child_we = 1'b1;
					node_we  = 1'b1;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!last_q) begin
					state_d = S_IDLE;
				end else if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
					if (verdict_d == V_GOOD) begin
						node_we    = 1'b1;
						node_waddr = cur_q;
						node_wdata = {1'b1, cur_slot_q};
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			next_free_q <= CNT_W'(1);
			made_q      <= 1'b0;
			met_q       <= 1'b0;
			bad_q       <= 1'b0;
			exh_q       <= 1'b0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RD_NODE) begin
				if (child_ok) begin
					cur_q <= child_rd;
					if (node_rd[SLOT_W]) begin
						met_q <= 1'b1;
					end
				end else if (has_room) begin
					cur_q       <= next_free_q[NODE_W-1:0];
					next_free_q <= next_free_q + CNT_W'(1);
					made_q      <= 1'b1;
				end else begin
					exh_q <= 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				if (seen_q != NUM_MAX) begin
					seen_q <= seen_q + NUM_W'(1);
				end
				if (verdict_d == V_BAD || verdict_d == V_FULL) begin
					bad_q <= 1'b1;
				end
				// Restart the walk at the root for the next string.
				cur_q  <= '0;
				made_q <= 1'b0;
				met_q  <= 1'b0;
				exh_q  <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			slot_q <= {cur_q, symbol};
			last_q <= last;
		end
		if (state_q == S_RD_NODE) begin
			cur_slot_q <= slot_q;
		end
		if (load_out) begin
			verdict_q <= verdict_d;
			number_q  <= seen_q;
		end
	end

	assign in_stall      = (state_q != S_IDLE);
	assign out_valid     = out_valid_q;
	assign verdict       = verdict_q;
	assign string_number = number_q;

	`ASSERT_CLK(a_cur_allocated, {1'b0, cur_q} < next_free_q, "walk sits on an unallocated node")
	`ASSERT_IMPLY(a_made_not_root, made_q, cur_q != '0, "new node made but walk is at the root")
	`ASSERT_IMPLY(a_exh_full, exh_q, next_free_q == NODES_C, "pool exhausted while nodes remain")
	`ASSERT_NEXT(a_bad_sticky, bad_q, bad_q, "bad flag cleared without reset")

endmodule
